[src/mdc_pkg.sv]
package mdc_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic REG_FAST_RELOAD = 1'b0;
  localparam logic REG_SLOW_RELOAD = 1'b1;

  localparam logic [2:0] SLOT_SEC_UP   = 3'd0;
  localparam logic [2:0] SLOT_SEC_DOWN = 3'd1;
  localparam logic [2:0] SLOT_HOUR_DN  = 3'd2;
  localparam logic [2:0] SLOT_MIN_UP   = 3'd3;
  localparam logic [2:0] SLOT_MIN_DOWN = 3'd4;
  localparam logic [2:0] SLOT_HOUR_UP  = 3'd5;
  localparam logic [2:0] SLOT_BLANK    = 3'd6;

  localparam logic [4:0] HOURS_PER_DAY = 5'd24;
  localparam logic [5:0] MINS_PER_HOUR = 6'd60;

  localparam logic [4:0] HOURS_RST   = 5'd20;
  localparam logic [5:0] MINUTES_RST = 6'd22;
  localparam logic [5:0] SECONDS_RST = 6'd22;
  localparam logic [7:0] FAST_RST    = 8'd192;
  localparam logic [7:0] SLOW_RST    = 8'd4;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } time_t;

  typedef struct packed {
    logic [7:0] fast_reload;
    logic [7:0] slow_reload;
  } cfg_t;

  typedef struct packed {
    logic [6:0] digit_select;
    logic [6:0] segments;
    time_t      now;
  } result_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  function automatic logic [6:0] seg_font(input logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'd0: p = 7'h3F;
      4'd1: p = 7'h06;
      4'd2: p = 7'h5B;
      4'd3: p = 7'h4F;
      4'd4: p = 7'h66;
      4'd5: p = 7'h6D;
      4'd6: p = 7'h7D;
      4'd7: p = 7'h07;
      4'd8: p = 7'h7F;
      4'd9: p = 7'h6F;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

  function automatic digits_t split_digits(input logic [5:0] v);
    digits_t r;
    logic [2:0] t;
    if (v >= 6'd60) t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else t = 3'd0;
    r.tens = {1'b0, t};
    r.ones = 4'(v - 6'({3'd0, t} * 6'd10));
    return r;
  endfunction

  function automatic time_t hour_up(input time_t t);
    time_t r;
    r = t;
    r.hours = (t.hours >= HOURS_PER_DAY - 5'd1) ? 5'd0 : t.hours + 5'd1;
    return r;
  endfunction

  function automatic time_t min_up(input time_t t);
    time_t r;
    r = t;
    if (t.minutes >= MINS_PER_HOUR - 6'd1) begin
      r = hour_up(t);
      r.minutes = 6'd0;
    end else begin
      r.minutes = t.minutes + 6'd1;
    end
    return r;
  endfunction

  function automatic time_t sec_up(input time_t t);
    time_t r;
    r = t;
    if (t.seconds >= MINS_PER_HOUR - 6'd1) begin
      r = min_up(t);
      r.seconds = 6'd0;
    end else begin
      r.seconds = t.seconds + 6'd1;
    end
    return r;
  endfunction

endpackage

[src/mdc_tick_if.sv]
interface mdc_tick_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink (input valid, input key_level, output ready);
endinterface

[src/mdc_result_if.sv]
interface mdc_result_if;
  logic       valid;
  logic       ready;
  logic [6:0] digit_select;
  logic [6:0] segments;
  logic [4:0] hours_now;
  logic [5:0] minutes_now;
  logic [5:0] seconds_now;

  modport source (output valid, output digit_select, output segments, output hours_now,
                  output minutes_now, output seconds_now, input ready);
  modport sink (input valid, input digit_select, input segments, input hours_now,
                input minutes_now, input seconds_now, output ready);
endinterface

[src/mdc_cfg.sv]
module mdc_cfg
  import mdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_reload <= FAST_RST;
      cfg.slow_reload <= SLOW_RST;
    end else if (wr) begin
      if (paddr[2] == REG_SLOW_RELOAD) begin
        cfg.slow_reload <= pwdata[7:0];
      end else begin
        cfg.fast_reload <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SLOW_RELOAD) ? {24'd0, cfg.slow_reload}
                                                 : {24'd0, cfg.fast_reload};

endmodule

[src/mdc_core.sv]
module mdc_core
  import mdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  logic    key_level,
  input  cfg_t    cfg,
  output result_t result
);

  time_t      tm;
  logic [2:0] scan_slot;
  logic [6:0] key_code;
  logic       key_latched;
  logic [7:0] fast_count;
  logic [7:0] slow_count;

  time_t      tm_key;
  time_t      tm_next;
  logic [2:0] scan_slot_next;
  logic [6:0] key_code_next;
  logic       key_latched_next;
  logic [7:0] fast_count_next;
  logic [7:0] slow_count_next;
  logic [6:0] strobe;
  logic [6:0] segs;
  logic [5:0] shown;
  digits_t    dg;

  always_comb begin
    strobe = 7'(8'd1 << scan_slot);
    case (scan_slot[2:1])
      2'd0: shown = tm.seconds;
      2'd1: shown = tm.minutes;
      default: shown = {1'b0, tm.hours};
    endcase
    dg = split_digits(shown);
    segs = 7'd0;
    tm_key = tm;
    key_code_next = key_code;
    key_latched_next = key_latched;
    scan_slot_next = 3'd0;
    if (scan_slot < SLOT_BLANK) begin
      segs = seg_font(scan_slot[0] ? dg.tens : dg.ones);
      scan_slot_next = scan_slot + 3'd1;
      if (key_level) begin
        key_code_next = strobe;
        if (!key_latched) begin
          key_latched_next = 1'b1;
          case (scan_slot)
            SLOT_SEC_UP:   tm_key = sec_up(tm);
            SLOT_SEC_DOWN: if (tm.seconds != 6'd0) tm_key.seconds = tm.seconds - 6'd1;
            SLOT_HOUR_DN:  if (tm.hours != 5'd0) tm_key.hours = tm.hours - 5'd1;
            SLOT_MIN_UP:   tm_key = min_up(tm);
            SLOT_MIN_DOWN: if (tm.minutes != 6'd0) tm_key.minutes = tm.minutes - 6'd1;
            default:       tm_key = hour_up(tm);
          endcase
        end
      end else if (key_code == strobe) begin
        key_latched_next = 1'b0;
      end
    end

    tm_next = tm_key;
    slow_count_next = slow_count;
    if (fast_count != 8'd0) begin
      fast_count_next = fast_count - 8'd1;
    end else begin
      fast_count_next = cfg.fast_reload;
      if (slow_count != 8'd0) begin
        slow_count_next = slow_count - 8'd1;
      end else begin
        slow_count_next = cfg.slow_reload;
        tm_next = sec_up(tm_key);
      end
    end

    result.digit_select = strobe;
    result.segments = segs;
    result.now = tm_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tm.hours <= HOURS_RST;
      tm.minutes <= MINUTES_RST;
      tm.seconds <= SECONDS_RST;
      scan_slot <= 3'd0;
      key_code <= 7'd0;
      key_latched <= 1'b0;
      fast_count <= FAST_RST;
      slow_count <= 8'd0;
    end else if (fire) begin
      tm <= tm_next;
      scan_slot <= scan_slot_next;
      key_code <= key_code_next;
      key_latched <= key_latched_next;
      fast_count <= fast_count_next;
      slow_count <= slow_count_next;
    end
  end

`ifndef ASSERT_OFF
  a_hours_range: assert property (@(posedge clk) disable iff (rst)
    tm.hours < HOURS_PER_DAY) else $error("hours out of range");
  a_minutes_range: assert property (@(posedge clk) disable iff (rst)
    tm.minutes < MINS_PER_HOUR) else $error("minutes out of range");
  a_seconds_range: assert property (@(posedge clk) disable iff (rst)
    tm.seconds < MINS_PER_HOUR) else $error("seconds out of range");
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    scan_slot <= SLOT_BLANK) else $error("scan slot out of range");
  a_latch_src: assert property (@(posedge clk) disable iff (rst)
    $rose(key_latched) |-> $past(key_level) && $past(fire)) else $error("latch without key");
`endif

endmodule

[src/multiplexed_digital_clock_unit.sv]
// Multiplexed clock: each tick beat carries one sampled key-return level and yields one
// result beat with the digit strobe and segment pattern of the current scan slot (time as
// it stood before the tick) plus the time after the tick. A tick is taken every cycle unless
// a held result stalls it; the whole update is one pass of counter and decode logic into a
// single result register, so the result beat is valid in the cycle after its tick and a
// stalled result blocks new ticks only while it is held. The prescaler reloads (APB
// offsets 0x0 fast, 0x4 slow) should be written while no beat is in flight.
module multiplexed_digital_clock_unit
  import mdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  mdc_tick_if.sink          tick,
  mdc_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  result_t res_d;
  result_t res_q;
  logic    res_valid;
  logic    fire;

  mdc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign tick.ready = !res_valid || result.ready;
  assign fire = tick.valid && tick.ready;

  mdc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .key_level (tick.key_level),
    .cfg       (cfg),
    .result    (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign result.valid = res_valid;
  assign result.digit_select = res_q.digit_select;
  assign result.segments = res_q.segments;
  assign result.hours_now = res_q.now.hours;
  assign result.minutes_now = res_q.now.minutes;
  assign result.seconds_now = res_q.now.seconds;

`ifndef ASSERT_OFF
  a_strobe_onehot: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot(res_q.digit_select)) else $error("bad digit strobe");
  a_blank_slot: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_q.digit_select[6] |-> res_q.segments == 7'd0) else $error("blank slot lit");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result.ready |=> res_valid && $stable(res_q)) else $error("result lost");
`endif

endmodule

[tb/mdc_clock_checker.sv]
`timescale 1ns / 1ps
module mdc_clock_checker
  import mdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  mdc_tick_if               tick,
  mdc_result_if             result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fail_count,
  output int                pending,
  output int                ticks_checked,
  output int                key_actions,
  output int                floor_hits,
  output int                day_rollovers
);

  time_t      clock_now;
  logic [2:0] scan;
  logic [6:0] key_strobe;
  logic       key_held;
  logic [7:0] fast_cnt;
  logic [7:0] slow_cnt;
  cfg_t       reload;
  result_t    expected_q[$];

  function automatic logic [6:0] glyph(input int d);
    logic [6:0] g;
    case (d)
      0: g = 7'h3F;
      1: g = 7'h06;
      2: g = 7'h5B;
      3: g = 7'h4F;
      4: g = 7'h66;
      5: g = 7'h6D;
      6: g = 7'h7D;
      7: g = 7'h07;
      8: g = 7'h7F;
      9: g = 7'h6F;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

  function automatic time_t hour_fwd(input time_t t);
    time_t r;
    r = t;
    if (t.hours >= 5'd23) begin
      r.hours = 5'd0;
      day_rollovers++;
    end else begin
      r.hours = t.hours + 5'd1;
    end
    return r;
  endfunction

  function automatic time_t minute_fwd(input time_t t);
    time_t r;
    r = t;
    if (t.minutes >= 6'd59) begin
      r = hour_fwd(t);
      r.minutes = 6'd0;
    end else begin
      r.minutes = t.minutes + 6'd1;
    end
    return r;
  endfunction

  function automatic time_t second_fwd(input time_t t);
    time_t r;
    r = t;
    if (t.seconds >= 6'd59) begin
      r = minute_fwd(t);
      r.seconds = 6'd0;
    end else begin
      r.seconds = t.seconds + 6'd1;
    end
    return r;
  endfunction

  // decrements stop at zero, no borrow
  function automatic void apply_slot(input logic [2:0] s);
    case (s)
      SLOT_SEC_UP: clock_now = second_fwd(clock_now);
      SLOT_SEC_DOWN: begin
        if (clock_now.seconds != 6'd0) clock_now.seconds = clock_now.seconds - 6'd1;
        else floor_hits++;
      end
      SLOT_HOUR_DN: begin
        if (clock_now.hours != 5'd0) clock_now.hours = clock_now.hours - 5'd1;
        else floor_hits++;
      end
      SLOT_MIN_UP: clock_now = minute_fwd(clock_now);
      SLOT_MIN_DOWN: begin
        if (clock_now.minutes != 6'd0) clock_now.minutes = clock_now.minutes - 6'd1;
        else floor_hits++;
      end
      default: clock_now = hour_fwd(clock_now);
    endcase
  endfunction

  function automatic result_t predict_tick(input logic key);
    result_t    r;
    logic [6:0] strobe;
    int         shown_val;
    strobe = 7'(32'd1 << scan);
    r.digit_select = strobe;
    r.segments = 7'h00;
    if (scan < SLOT_BLANK) begin
      case (scan[2:1])
        2'd0: shown_val = int'(clock_now.seconds);
        2'd1: shown_val = int'(clock_now.minutes);
        default: shown_val = int'(clock_now.hours);
      endcase
      r.segments = scan[0] ? glyph((shown_val / 10) % 10) : glyph(shown_val % 10);
      if (key) begin
        key_strobe = strobe;
        if (!key_held) begin
          apply_slot(scan);
          key_held = 1'b1;
          key_actions++;
        end
      end else if (key_strobe == strobe) begin
        key_held = 1'b0;
      end
      scan = scan + 3'd1;
    end else begin
      scan = 3'd0;
    end

    if (fast_cnt != 8'd0) begin
      fast_cnt = fast_cnt - 8'd1;
    end else begin
      fast_cnt = reload.fast_reload;
      if (slow_cnt != 8'd0) begin
        slow_cnt = slow_cnt - 8'd1;
      end else begin
        slow_cnt = reload.slow_reload;
        clock_now = second_fwd(clock_now);
      end
    end
    r.now = clock_now;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      clock_now = {HOURS_RST, MINUTES_RST, SECONDS_RST};
      scan = 3'd0;
      key_strobe = 7'd0;
      key_held = 1'b0;
      fast_cnt = FAST_RST;
      slow_cnt = 8'd0;
      reload = {FAST_RST, SLOW_RST};
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_FAST_RELOAD: reload.fast_reload = pwdata[7:0];
          REG_SLOW_RELOAD: reload.slow_reload = pwdata[7:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no tick outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("digit_select", 8'(want.digit_select), 8'(result.digit_select));
          check_field("segments", 8'(want.segments), 8'(result.segments));
          check_field("hours_now", 8'(want.now.hours), 8'(result.hours_now));
          check_field("minutes_now", 8'(want.now.minutes), 8'(result.minutes_now));
          check_field("seconds_now", 8'(want.now.seconds), 8'(result.seconds_now));
          ticks_checked++;
        end
      end
      if (tick.valid && tick.ready) expected_q.push_back(predict_tick(tick.key_level));
    end
    pending = expected_q.size();
  end

endmodule

[tb/multiplexed_digital_clock_unit_tb.sv]
`timescale 1ns / 1ps
module multiplexed_digital_clock_unit_tb;
  import mdc_pkg::*;

  localparam int SCAN_SLOTS = 7;
  localparam int DIRECTED_TICKS = 26;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [ADDR_W-1:0] FAST_ADDR = ADDR_W'({REG_FAST_RELOAD, 2'b00});
  localparam logic [ADDR_W-1:0] SLOW_ADDR = ADDR_W'({REG_SLOW_RELOAD, 2'b00});

  typedef enum int {PRESS_UP, PRESS_DOWN, PRESS_ANY} press_mix_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;

  int          fail_count;
  int          pending;
  int          ticks_checked;
  int          key_actions;
  int          floor_hits;
  int          day_rollovers;
  int unsigned cycle_count;

  int         sent_count;
  int         burst_left;
  int         held;
  int         target;
  int         noise_pct;
  press_mix_t mix;
  time_t      shown_time;
  bit         squeeze;
  bit         squeezed;

  mdc_tick_if   tick ();
  mdc_result_if result ();

  multiplexed_digital_clock_unit dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mdc_clock_checker chk (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .result        (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .ticks_checked (ticks_checked),
    .key_actions   (key_actions),
    .floor_hits    (floor_hits),
    .day_rollovers (day_rollovers)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (result.valid && result.ready)
      shown_time <= {result.hours_now, result.minutes_now, result.seconds_now};
  end

  // down presses favour whatever is still above zero
  function automatic int pick_target();
    int roll;
    int t;
    int any_down;
    roll = $urandom_range(0, 99);
    t = $urandom_range(SLOT_SEC_UP, SLOT_HOUR_UP);
    any_down = (roll % 3 == 0) ? SLOT_SEC_DOWN : (roll % 3 == 1) ? SLOT_HOUR_DN : SLOT_MIN_DOWN;
    case (mix)
      PRESS_UP: begin
        if (roll < 60) t = SLOT_MIN_UP;
        else if (roll < 80) t = SLOT_HOUR_UP;
        else t = SLOT_SEC_UP;
      end
      PRESS_DOWN: begin
        if (roll < 10) t = any_down;
        else if (shown_time.hours != 0 && roll < 45) t = SLOT_HOUR_DN;
        else if (shown_time.minutes != 0 && roll < 75) t = SLOT_MIN_DOWN;
        else if (shown_time.seconds != 0) t = SLOT_SEC_DOWN;
        else if (shown_time.hours != 0) t = SLOT_HOUR_DN;
        else if (shown_time.minutes != 0) t = SLOT_MIN_DOWN;
        else t = any_down;
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic logic next_key();
    int s;
    s = sent_count % SCAN_SLOTS;
    if ($urandom_range(0, 99) < noise_pct || s == SLOT_BLANK) return 1'($urandom_range(0, 1));
    if (held >= 0) return (s == held) && ($urandom_range(0, 3) == 0);
    return s == target;
  endfunction

  task automatic issue(input logic key);
    int gap;
    int s;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        tick.valid <= 1'b0;
        tick.key_level <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tick.valid <= 1'b1;
    tick.key_level <= key;
    @(posedge clk);
    while (!tick.ready) @(posedge clk);
    // mirror the key latch so presses land on a released key
    s = sent_count % SCAN_SLOTS;
    if (s != SLOT_BLANK) begin
      if (key) begin
        if (held < 0) target = pick_target();
        held = s;
      end else if (s == held) begin
        held = -1;
      end
    end
    sent_count++;
  endtask

  task automatic drain();
    tick.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_presses(input press_mix_t m, input int items, input int noise);
    mix = m;
    noise_pct = noise;
    target = pick_target();
    repeat (items) issue(next_key());
  endtask

  initial begin
    int mode;
    int run_left;
    logic rdy;
    result.ready = 1'b0;
    mode = 0;
    run_left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        result.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (run_left == 0) begin
        mode = $urandom_range(0, 3);
        run_left = $urandom_range(8, 60);
      end
      run_left--;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = $urandom_range(0, 7) != 0;
        default: rdy = $urandom_range(0, 3) == 0;
      endcase
      result.ready <= rdy;
      @(posedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    tick.valid = 1'b0;
    tick.key_level = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    held = -1;
    burst_left = 0;
    sent_count = 0;
    mix = PRESS_ANY;
    noise_pct = 0;
    target = SLOT_SEC_UP;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // whole scan high, then blank slot high, then a lone minute-down press
    for (int i = 0; i < DIRECTED_TICKS; i++)
      issue(i < SCAN_SLOTS || i == SCAN_SLOTS + SLOT_BLANK ||
            i == 2 * SCAN_SLOTS + SLOT_MIN_DOWN);

    drain();
    apb_write(FAST_ADDR, 8'd0);
    apb_write(SLOW_ADDR, 8'd0);
    run_presses(PRESS_UP, 300, 5);

    drain();
    apb_write(FAST_ADDR, 8'd255);
    apb_write(SLOW_ADDR, 8'd255);
    run_presses(PRESS_DOWN, 650, 5);

    drain();
    apb_write(FAST_ADDR, 8'($urandom_range(1, 6)));
    apb_write(SLOW_ADDR, 8'($urandom_range(0, 2)));
    squeeze = 1'b1;
    run_presses(PRESS_ANY, 200, 20);

    drain();
    $display("summary: %0d ticks checked over four prescaler settings, one %0d-cycle hold-off",
             ticks_checked, HOLD_OFF_CYCLES);
    $display("summary: %0d key actions, %0d presses at zero, %0d midnight roll-overs",
             key_actions, floor_hits, day_rollovers);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
